// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Command and status codes, field widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int TAG_W     = 16;
  localparam int PRI_W     = 8;
  localparam int OCC_W     = 5;

  // command codes on the request channel
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // broadcast from the control logic to every cell
  typedef struct packed {
    logic             ins;   // insert this cycle (queue not full)
    logic             rem;   // remove this cycle (queue not empty)
    logic [TAG_W-1:0] tag;
    logic [PRI_W-1:0] pri;
  } cell_ctrl_t;

endpackage

// ----- design/spq_req_if.sv -----
// ----------------------------------------------------------------------------
// spq_req_if: request channel of the sorted priority queue
// Valid/ready handshake carrying one insert or remove command.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [spq_pkg::TAG_W-1:0] tag;
  logic [spq_pkg::PRI_W-1:0] priority_req;

  modport source (output valid, cmd, tag, priority_req, input ready);
  modport sink   (input valid, cmd, tag, priority_req, output ready);
endinterface

// ----- design/spq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spq_rsp_if: response channel of the sorted priority queue
// Valid/ready handshake carrying status, served entry and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [spq_pkg::TAG_W-1:0] out_tag;
  logic [spq_pkg::PRI_W-1:0] out_priority;
  logic [spq_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, status, out_tag, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_tag, out_priority, occupancy, output ready);
endinterface

// ----- design/sorted_priority_queue.sv -----
// A result is registered on its request transaction and is valid in the cycle after it.
// Throughput: one insert or remove per cycle; every slot compares its own
//   priority with the new one in parallel and shifts by one cell per command.
// The result register frees as it is taken, so a stalled response holds input.
// Reset: synchronous, clears the entry count and result valid; slot contents
//   are not cleared and are never read before written.
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept sorted in a cell chain
// Highest priority at cell 0, equal priorities first-in first-out. Inserts
// into a full queue are dropped, removes from an empty queue report empty.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [spq_pkg::OCC_W-1:0]  occ_next;
  logic [spq_pkg::OCC_W-1:0]  occ_now;
  logic                       accept;
  logic                       full;
  logic                       empty;
  logic                       ins_ok;
  logic                       rem_ok;
  spq_pkg::cell_ctrl_t        ctrl;
  spq_pkg::status_t           status_next;
  logic                       rsp_valid;

  logic [DEPTH-1:0]           cell_ge;
  logic [spq_pkg::TAG_W-1:0]  cell_tag [DEPTH];
  logic [spq_pkg::PRI_W-1:0]  cell_pri [DEPTH];

  // handshake and command decode
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign ins_ok    = accept && (req.cmd == spq_pkg::CMD_INSERT) && !full;
  assign rem_ok    = accept && (req.cmd == spq_pkg::CMD_REMOVE) && !empty;

  assign ctrl.ins = ins_ok;
  assign ctrl.rem = rem_ok;
  assign ctrl.tag = req.tag;
  assign ctrl.pri = req.priority_req;

  // entry count
  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + 1'b1;
    end else if (rem_ok) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // occupancy is the count held in the fixed output width
  generate
    if (CW >= spq_pkg::OCC_W) begin : g_occ_trunc
      assign occ_next = count_next[spq_pkg::OCC_W-1:0];
      assign occ_now  = count[spq_pkg::OCC_W-1:0];
    end else begin : g_occ_ext
      assign occ_next = {{(spq_pkg::OCC_W - CW){1'b0}}, count_next};
      assign occ_now  = {{(spq_pkg::OCC_W - CW){1'b0}}, count};
    end
  endgenerate

  // chain of slots, head at cell 0
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      l_ge;
      logic [spq_pkg::TAG_W-1:0] l_tag;
      logic [spq_pkg::PRI_W-1:0] l_pri;
      logic [spq_pkg::TAG_W-1:0] r_tag;
      logic [spq_pkg::PRI_W-1:0] r_pri;

      if (i == 0) begin : g_head
        assign l_ge  = 1'b1;
        assign l_tag = '0;
        assign l_pri = '0;
      end else begin : g_mid
        assign l_ge  = cell_ge[i-1];
        assign l_tag = cell_tag[i-1];
        assign l_pri = cell_pri[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_tag = '0;
        assign r_pri = '0;
      end else begin : g_body
        assign r_tag = cell_tag[i+1];
        assign r_pri = cell_pri[i+1];
      end

      spq_cell #(
        .DEPTH (DEPTH),
        .IDX   (i)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (count),
        .left_ge   (l_ge),
        .left_tag  (l_tag),
        .left_pri  (l_pri),
        .right_tag (r_tag),
        .right_pri (r_pri),
        .ge        (cell_ge[i]),
        .tag       (cell_tag[i]),
        .pri       (cell_pri[i])
      );
    end
  endgenerate

  // result status
  always_comb begin
    if (req.cmd == spq_pkg::CMD_INSERT) begin
      status_next = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
    end else begin
      status_next = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_SERVED;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status       <= status_next;
      rsp.out_tag      <= rem_ok ? cell_tag[0] : '0;
      rsp.out_priority <= rem_ok ? cell_pri[0] : '0;
      rsp.occupancy    <= occ_next;
    end
  end

  assign rsp.valid = rsp_valid;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the count");

  a_occ_tracks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.occupancy == occ_now)
    else $error("pending occupancy differs from entry count");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (rem_ok && count > CW'(1)) |=> cell_pri[0] <= rsp.out_priority)
    else $error("new head outranks the served entry");

endmodule

// ----- design/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one tag/priority pair. On insert it keeps, takes the new entry or
// takes its left neighbor; on remove it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  spq_pkg::cell_ctrl_t       ctrl,
  input  logic [CW-1:0]             count,
  input  logic                      left_ge,
  input  logic [spq_pkg::TAG_W-1:0] left_tag,
  input  logic [spq_pkg::PRI_W-1:0] left_pri,
  input  logic [spq_pkg::TAG_W-1:0] right_tag,
  input  logic [spq_pkg::PRI_W-1:0] right_pri,
  output logic                      ge,
  output logic [spq_pkg::TAG_W-1:0] tag,
  output logic [spq_pkg::PRI_W-1:0] pri
);

  logic [spq_pkg::TAG_W-1:0] tag_next;
  logic [spq_pkg::PRI_W-1:0] pri_next;

  // occupied slot that stays ahead of the new entry
  assign ge = (count > CW'(IDX)) && (pri >= ctrl.pri);

  always_comb begin
    tag_next = tag;
    pri_next = pri;
    if (ctrl.ins && !ge) begin
      if (left_ge) begin
        tag_next = ctrl.tag;
        pri_next = ctrl.pri;
      end else begin
        tag_next = left_tag;
        pri_next = left_pri;
      end
    end else if (ctrl.rem) begin
      tag_next = right_tag;
      pri_next = right_pri;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    tag <= tag_next;
    pri <= pri_next;
  end

endmodule
